/* src/ffsa_pkg.sv */
// Package for the first-fit segment allocator: payload structs, request codes,
// controller states and sizing constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

   localparam int MEM_BYTES_DEF = 1024;
   localparam int MAX_SEGS_DEF  = 16;

   typedef enum logic [1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_DEFRAG = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] req_size;
      logic [9:0]  req_addr;
   } req_type_s_type;

   typedef struct packed {
      logic [9:0] result_addr;
      logic       ok;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_DEFRAG,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

/* src/ffsa_cell.sv */
// One segment table entry of the allocator chain. Holds start, size, used and
// a valid bit, and hands its contents to its right neighbor on a shift.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell
   import ffsa_pkg::*;
#(
   parameter int AW = 10,
   parameter int SW = 11
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           rst_valid,
   input  wire logic [SW-1:0]  rst_size,
   input  wire logic           wr_en,
   input  wire logic           wr_valid,
   input  wire logic [AW-1:0]  wr_start,
   input  wire logic [SW-1:0]  wr_size,
   input  wire logic           wr_used,
   output logic                valid,
   output logic [AW-1:0]       start,
   output logic [SW-1:0]       size,
   output logic                used
);

   logic          valid_ff, used_ff;
   logic [AW-1:0] start_ff;
   logic [SW-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= rst_valid;
         used_ff  <= 1'b0;
         start_ff <= '0;
         size_ff  <= rst_size;
      end else if (wr_en) begin
         valid_ff <= wr_valid;
         used_ff  <= wr_used;
         start_ff <= wr_start;
         size_ff  <= wr_size;
      end
   end

   assign valid = valid_ff;
   assign start = start_ff;
   assign size  = size_ff;
   assign used  = used_ff;

endmodule
`default_nettype wire

/* src/first_fit_segment_allocator_top.sv */
// Top level of the first-fit segment allocator: controller and the chain of
// segment cells. Depends on ffsa_pkg and ffsa_cell.
`timescale 1ns / 1ps
`default_nettype none
// The allocator keeps an address-ordered table of up to MAX_SEGS segments in a
// chain of cells, reset to one free segment covering MEM_BYTES bytes. A
// transaction is taken when start is high and busy is low; exactly one result
// follows, shown on rsp_data for one cycle with done high, and the receiver
// cannot stall it. The controller visits one cell per cycle: allocate and
// free scan up to MAX_SEGS cells, a split then ripples the tail of the chain
// one cell per cycle, and defragment walks every entry of the table once
// while used entries are compacted toward the head. A new transaction is
// taken only after the result of the last one has been shown.
module first_fit_segment_allocator_top
   import ffsa_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEF,
   parameter int MAX_SEGS  = MAX_SEGS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   input  wire req_type_s_type req_data,
   output logic                done,
   output rsp_type             rsp_data
);

   localparam int AW = $clog2(MEM_BYTES + 1);
   localparam int SW = $clog2(MEM_BYTES + 1);
   localparam int IW = $clog2(MAX_SEGS);
   localparam int CW = $clog2(MAX_SEGS + 1);

   state_type state_ff, state_in;
   req_type_s_type req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;   // scan pointer
   logic [CW-1:0] cnt_ff, cnt_in;   // segment count
   logic [CW-1:0] wr_ff, wr_in;     // defragment write pointer
   logic [AW-1:0] pos_ff, pos_in;   // defragment running address
   rsp_type rsp_ff, rsp_in;
   logic done_ff, done_in;

   logic [MAX_SEGS-1:0]         c_valid, c_used, c_we, c_wvalid, c_wused;
   logic [MAX_SEGS-1:0][AW-1:0] c_start, c_wstart;
   logic [MAX_SEGS-1:0][SW-1:0] c_size, c_wsize;

   genvar g;
   generate
      for (g = 0; g < MAX_SEGS; g++) begin : g_cell
         ffsa_cell #(.AW(AW), .SW(SW)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .rst_valid(g == 0),
            .rst_size ((g == 0) ? SW'(MEM_BYTES) : SW'(0)),
            .wr_en    (c_we[g]),
            .wr_valid (c_wvalid[g]),
            .wr_start (c_wstart[g]),
            .wr_size  (c_wsize[g]),
            .wr_used  (c_wused[g]),
            .valid    (c_valid[g]),
            .start    (c_start[g]),
            .size     (c_size[g]),
            .used     (c_used[g])
         );
      end
   endgenerate

   logic [IW-1:0] idx;
   logic [IW-1:0] wr;
   logic [AW-1:0] cur_start;
   logic [SW-1:0] cur_size;
   logic          cur_used;
   logic [SW-1:0] want;
   logic          in_range;

   assign idx       = idx_ff[IW-1:0];
   assign wr        = wr_ff[IW-1:0];
   assign cur_start = c_start[idx];
   assign cur_size  = c_size[idx];
   assign cur_used  = c_used[idx];
   assign want      = SW'(req_ff.req_size);
   assign in_range  = (idx_ff < cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= CW'(1);
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      wr_ff  <= wr_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      wr_in    = wr_ff;
      pos_in   = pos_ff;
      rsp_in   = rsp_ff;
      done_in  = 1'b0;
      c_we     = '0;
      c_wvalid = c_valid;
      c_wstart = c_start;
      c_wsize  = c_size;
      c_wused  = c_used;
      unique case (state_ff)
         ST_IDLE: begin
            // The result strobe cycle still counts as busy.
            if (start && !busy) begin
               req_in   = req_data;
               idx_in   = '0;
               wr_in    = '0;
               pos_in   = '0;
               rsp_in   = '0;
               unique case (req_code_type'(req_data.req_type))
                  REQ_ALLOC:  state_in = (req_data.req_size == '0) ? ST_DONE : ST_SCAN;
                  REQ_FREE:   state_in = ST_SCAN;
                  REQ_DEFRAG: state_in = ST_DEFRAG;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (!in_range) begin
               state_in = ST_DONE;
            end else if (req_ff.req_type == REQ_FREE) begin
               if (cur_start == AW'(req_ff.req_addr)) begin
                  c_we[idx]    = 1'b1;
                  c_wused[idx] = 1'b0;
                  rsp_in.ok    = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (!cur_used && cur_size >= want) begin
               if (cur_size == want) begin
                  c_we[idx]          = 1'b1;
                  c_wused[idx]       = 1'b1;
                  rsp_in.ok          = 1'b1;
                  rsp_in.result_addr = 10'(cur_start);
                  state_in           = ST_DONE;
               end else if (cnt_ff >= CW'(MAX_SEGS)) begin
                  state_in = ST_DONE;
               end else begin
                  // Ripple the tail right one cell per cycle, from the end.
                  wr_in    = cnt_ff;
                  state_in = ST_SHIFT;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SHIFT: begin
            if (wr_ff > idx_ff + 1'b1) begin
               c_we[wr]     = 1'b1;
               c_wvalid[wr] = 1'b1;
               c_wstart[wr] = c_start[wr-1'b1];
               c_wsize[wr]  = c_size[wr-1'b1];
               c_wused[wr]  = c_used[wr-1'b1];
               wr_in        = wr_ff - 1'b1;
            end else begin
               c_we[idx]      = 1'b1;
               c_wsize[idx]   = want;
               c_wused[idx]   = 1'b1;
               c_we[wr]       = 1'b1;
               c_wvalid[wr]   = 1'b1;
               c_wstart[wr]   = cur_start + AW'(want);
               c_wsize[wr]    = cur_size - want;
               c_wused[wr]    = 1'b0;
               cnt_in         = cnt_ff + 1'b1;
               rsp_in.ok          = 1'b1;
               rsp_in.result_addr = 10'(cur_start);
               state_in       = ST_DONE;
            end
         end
         ST_DEFRAG: begin
            if (in_range) begin
               if (cur_used) begin
                  c_we[wr]     = 1'b1;
                  c_wvalid[wr] = 1'b1;
                  c_wstart[wr] = pos_ff;
                  c_wsize[wr]  = cur_size;
                  c_wused[wr]  = 1'b1;
                  pos_in       = pos_ff + AW'(cur_size);
                  wr_in        = wr_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               rsp_in.ok = 1'b1;
               if (wr_ff >= CW'(MAX_SEGS)) begin
                  cnt_in = wr_ff;
               end else begin
                  c_we[wr]     = 1'b1;
                  c_wvalid[wr] = 1'b1;
                  c_wstart[wr] = pos_ff;
                  c_wsize[wr]  = SW'(MEM_BYTES) - SW'(pos_ff);
                  c_wused[wr]  = 1'b0;
                  cnt_in       = wr_ff + 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy     = (state_ff != ST_IDLE) || done_ff;
   assign done     = done_ff;
   assign rsp_data = done_ff ? rsp_ff : '0;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff >= CW'(1) && cnt_ff <= CW'(MAX_SEGS))
      else $error("segment count out of range");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("result strobe longer than one cycle");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> busy)
      else $error("request possible while result shown");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !rsp_ff.ok) |-> rsp_ff.result_addr == '0)
      else $error("failed request with nonzero address");

endmodule
`default_nettype wire
